### rtl/wsf_pkg.sv
// ----------------------------------------------------------------------------
// wsf_pkg
// Shared constants, types and helpers for the windowed sensor filter.
// ----------------------------------------------------------------------------
package wsf_pkg;

    localparam int WINDOW_DEPTH    = 64;
    localparam int SAMPLE_BITS     = 32;
    localparam int COEFF_FRAC_BITS = 16;

    localparam int ADDR_BITS   = $clog2(WINDOW_DEPTH);
    localparam int CNT_BITS    = $clog2(WINDOW_DEPTH + 1);
    localparam int COEFF_BITS  = COEFF_FRAC_BITS + 1;
    localparam int WIN_BITS    = 7;
    localparam int CFG_BITS    = (COEFF_BITS > WIN_BITS) ? COEFF_BITS : WIN_BITS;
    localparam int SUM_BITS    = 64;
    localparam int DCNT_BITS   = $clog2(SUM_BITS);
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int PROD_BITS   = COEFF_BITS + 1 + DIFF_BITS;
    localparam int ACC_BITS    = PROD_BITS + 1;
    localparam int SAT_BITS    = (ACC_BITS > SUM_BITS + 1) ? ACC_BITS : SUM_BITS + 1;
    localparam int READY_SCALE = 10;
    localparam int RDY_BITS    = CNT_BITS + 4;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOWPASS,
        MODE_HIGHPASS,
        MODE_AVERAGE,
        MODE_PASS
    } mode_t;

    typedef enum logic [1:0] {
        REG_FILTER_MODE,
        REG_WINDOW_SIZE,
        REG_LOWPASS_COEFF,
        REG_HIGHPASS_COEFF
    } reg_index_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLEAR,
        DP_Y_X,
        DP_RD_OLD,
        DP_DROP,
        DP_APPEND,
        DP_SUM_SET,
        DP_SUM_ADD,
        DP_RD_FIRST,
        DP_Y_INIT,
        DP_RD_IDX,
        DP_MUL_A,
        DP_MUL_B,
        DP_UPD_LP,
        DP_UPD_HP,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_Y_DIV,
        DP_RESULT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_F_PRE,
        S_F_APP,
        S_F_POST,
        S_F_CHK,
        S_F_INIT,
        S_F_RD,
        S_F_MA,
        S_F_MB,
        S_F_UP,
        S_A_FIRST,
        S_A_SETS,
        S_A_RD1,
        S_A_DR1,
        S_A_APP,
        S_A_CHK,
        S_A_DR2,
        S_A_ADD,
        S_A_DIVI,
        S_A_DIV,
        S_A_DIVF,
        S_FIN
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   sub;
        logic   lowpass;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic ge_eff;
        logic gt_eff;
        logic full;
        logic lt2;
        logic idx_done;
        logic div_last;
    } status_t;

    // (ptr + off) modulo the window depth; off never exceeds the depth
    function automatic logic [ADDR_BITS-1:0] wrap_add(input logic [ADDR_BITS-1:0] ptr,
                                                      input logic [CNT_BITS-1:0] off);
        logic [CNT_BITS:0] s;
        s = (CNT_BITS+1)'(ptr) + (CNT_BITS+1)'(off);
        if (s >= (CNT_BITS+1)'(WINDOW_DEPTH))
        begin
            s = s - (CNT_BITS+1)'(WINDOW_DEPTH);
        end
        return s[ADDR_BITS-1:0];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic [SAT_BITS-1:0] v);
        logic [SAT_BITS-SAMPLE_BITS:0] hi;
        logic [SAMPLE_BITS-1:0]        r;
        hi = v[SAT_BITS-1:SAMPLE_BITS-1];
        if ((&hi) || !(|hi))
        begin
            r = v[SAMPLE_BITS-1:0];
        end
        else if (v[SAT_BITS-1])
        begin
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### rtl/wsf_ctrl.sv
// ----------------------------------------------------------------------------
// wsf_ctrl
// Sequencer: steps the datapath through history update, recursion and
// division for one word at a time, and owns the output handshake.
// ----------------------------------------------------------------------------
module wsf_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 operation,
    input  wsf_pkg::mode_t       mode,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  wsf_pkg::status_t     status,
    output wsf_pkg::cmd_t        cmd
);

    wsf_pkg::ctrl_state_t state_reg, state_next;
    logic                 op_reg, op_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != wsf_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wsf_pkg::S_IDLE;
            op_reg        <= wsf_pkg::OP_PUSH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            wsf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    state_next = wsf_pkg::S_DISP;
                end
            end
            wsf_pkg::S_DISP:
            begin
                if (op_reg == wsf_pkg::OP_CLEAR || mode == wsf_pkg::MODE_PASS)
                begin
                    state_next = wsf_pkg::S_FIN;
                end
                else if (mode == wsf_pkg::MODE_AVERAGE)
                begin
                    if (status.empty)
                    begin
                        state_next = wsf_pkg::S_A_FIRST;
                    end
                    else if (status.ge_eff)
                    begin
                        state_next = wsf_pkg::S_A_RD1;
                    end
                    else
                    begin
                        state_next = wsf_pkg::S_A_APP;
                    end
                end
                else
                begin
                    state_next = wsf_pkg::S_F_PRE;
                end
            end
            wsf_pkg::S_F_PRE:   state_next = wsf_pkg::S_F_APP;
            wsf_pkg::S_F_APP:   state_next = wsf_pkg::S_F_POST;
            wsf_pkg::S_F_POST:  state_next = wsf_pkg::S_F_CHK;
            wsf_pkg::S_F_CHK:
            begin
                state_next = status.lt2 ? wsf_pkg::S_FIN : wsf_pkg::S_F_INIT;
            end
            wsf_pkg::S_F_INIT:  state_next = wsf_pkg::S_F_RD;
            wsf_pkg::S_F_RD:
            begin
                state_next = status.idx_done ? wsf_pkg::S_FIN : wsf_pkg::S_F_MA;
            end
            wsf_pkg::S_F_MA:
            begin
                state_next = (mode == wsf_pkg::MODE_LOWPASS) ? wsf_pkg::S_F_UP
                                                              : wsf_pkg::S_F_MB;
            end
            wsf_pkg::S_F_MB:    state_next = wsf_pkg::S_F_UP;
            wsf_pkg::S_F_UP:    state_next = wsf_pkg::S_F_RD;
            wsf_pkg::S_A_FIRST: state_next = wsf_pkg::S_A_SETS;
            wsf_pkg::S_A_SETS:  state_next = wsf_pkg::S_FIN;
            wsf_pkg::S_A_RD1:   state_next = wsf_pkg::S_A_DR1;
            wsf_pkg::S_A_DR1:   state_next = wsf_pkg::S_A_APP;
            wsf_pkg::S_A_APP:   state_next = wsf_pkg::S_A_CHK;
            wsf_pkg::S_A_CHK:
            begin
                state_next = status.gt_eff ? wsf_pkg::S_A_DR2 : wsf_pkg::S_A_ADD;
            end
            wsf_pkg::S_A_DR2:   state_next = wsf_pkg::S_A_ADD;
            wsf_pkg::S_A_ADD:   state_next = wsf_pkg::S_A_DIVI;
            wsf_pkg::S_A_DIVI:  state_next = wsf_pkg::S_A_DIV;
            wsf_pkg::S_A_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = wsf_pkg::S_A_DIVF;
                end
            end
            wsf_pkg::S_A_DIVF:  state_next = wsf_pkg::S_FIN;
            wsf_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    state_next = wsf_pkg::S_IDLE;
                end
            end
            default:            state_next = wsf_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op         = wsf_pkg::DP_NOP;
        cmd.sub        = 1'b0;
        cmd.lowpass    = (mode == wsf_pkg::MODE_LOWPASS);
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            wsf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = wsf_pkg::DP_LOAD;
                end
            end
            wsf_pkg::S_DISP:
            begin
                if (op_reg == wsf_pkg::OP_CLEAR)
                begin
                    cmd.op = wsf_pkg::DP_CLEAR;
                end
                else if (mode == wsf_pkg::MODE_PASS)
                begin
                    cmd.op = wsf_pkg::DP_Y_X;
                end
            end
            wsf_pkg::S_F_PRE:
            begin
                if (status.full)
                begin
                    cmd.op = wsf_pkg::DP_DROP;
                end
            end
            wsf_pkg::S_F_APP:   cmd.op = wsf_pkg::DP_APPEND;
            wsf_pkg::S_F_POST:
            begin
                if (status.gt_eff)
                begin
                    cmd.op = wsf_pkg::DP_DROP;
                end
            end
            wsf_pkg::S_F_CHK:
            begin
                cmd.op = status.lt2 ? wsf_pkg::DP_Y_X : wsf_pkg::DP_RD_FIRST;
            end
            wsf_pkg::S_F_INIT:  cmd.op = wsf_pkg::DP_Y_INIT;
            wsf_pkg::S_F_RD:
            begin
                if (!status.idx_done)
                begin
                    cmd.op = wsf_pkg::DP_RD_IDX;
                end
            end
            wsf_pkg::S_F_MA:    cmd.op = wsf_pkg::DP_MUL_A;
            wsf_pkg::S_F_MB:    cmd.op = wsf_pkg::DP_MUL_B;
            wsf_pkg::S_F_UP:
            begin
                cmd.op = (mode == wsf_pkg::MODE_LOWPASS) ? wsf_pkg::DP_UPD_LP
                                                          : wsf_pkg::DP_UPD_HP;
            end
            wsf_pkg::S_A_FIRST: cmd.op = wsf_pkg::DP_APPEND;
            wsf_pkg::S_A_SETS:  cmd.op = wsf_pkg::DP_SUM_SET;
            wsf_pkg::S_A_RD1:   cmd.op = wsf_pkg::DP_RD_OLD;
            wsf_pkg::S_A_DR1:
            begin
                cmd.op  = wsf_pkg::DP_DROP;
                cmd.sub = 1'b1;
            end
            wsf_pkg::S_A_APP:   cmd.op = wsf_pkg::DP_APPEND;
            wsf_pkg::S_A_CHK:
            begin
                if (status.gt_eff)
                begin
                    cmd.op = wsf_pkg::DP_RD_OLD;
                end
            end
            wsf_pkg::S_A_DR2:
            begin
                cmd.op  = wsf_pkg::DP_DROP;
                cmd.sub = 1'b1;
            end
            wsf_pkg::S_A_ADD:   cmd.op = wsf_pkg::DP_SUM_ADD;
            wsf_pkg::S_A_DIVI:  cmd.op = wsf_pkg::DP_DIV_INIT;
            wsf_pkg::S_A_DIV:   cmd.op = wsf_pkg::DP_DIV_STEP;
            wsf_pkg::S_A_DIVF:  cmd.op = wsf_pkg::DP_Y_DIV;
            wsf_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    cmd.op         = wsf_pkg::DP_RESULT;
                    out_valid_next = 1'b1;
                end
            end
            default:            cmd.op = wsf_pkg::DP_NOP;
        endcase
    end

endmodule

### rtl/wsf_dpath.sv
// ----------------------------------------------------------------------------
// wsf_dpath
// History memory, pointers, running sum, shared coefficient multiplier,
// serial divider and the output word register.
// ----------------------------------------------------------------------------
module wsf_dpath
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  wsf_pkg::cmd_t                             cmd,
    input  logic signed [wsf_pkg::SAMPLE_BITS-1:0]    sample_in,
    input  logic [wsf_pkg::CNT_BITS-1:0]              eff_window,
    input  logic [wsf_pkg::COEFF_BITS-1:0]            lowpass_coeff,
    input  logic [wsf_pkg::COEFF_BITS-1:0]            highpass_coeff,
    output wsf_pkg::status_t                          status,
    output logic signed [wsf_pkg::SAMPLE_BITS-1:0]    filtered_out,
    output logic                                      ready_res
);

    localparam int S = wsf_pkg::SAMPLE_BITS;

    logic signed [S-1:0] mem [wsf_pkg::WINDOW_DEPTH];

    logic [wsf_pkg::ADDR_BITS-1:0]          ptr_reg, ptr_next;
    logic [wsf_pkg::CNT_BITS-1:0]           count_reg, count_next;
    logic [wsf_pkg::SUM_BITS-1:0]           sum_reg, sum_next;
    logic [wsf_pkg::CNT_BITS-1:0]           idx_reg, idx_next;
    logic [wsf_pkg::DCNT_BITS-1:0]          dcnt_reg, dcnt_next;
    logic signed [S-1:0]                    x_reg, y_reg, prev_reg, cur_reg, rd_data_reg;
    logic signed [wsf_pkg::PROD_BITS-1:0]   prod_a_reg, prod_b_reg;
    logic [wsf_pkg::SUM_BITS-1:0]           mag_reg;
    logic [wsf_pkg::CNT_BITS-1:0]           rem_reg;
    logic                                   neg_reg;
    logic signed [S-1:0]                    out_reg;
    logic                                   ready_reg;

    logic [wsf_pkg::ADDR_BITS-1:0]          rd_addr, wr_addr;
    logic                                   rd_en;
    logic [wsf_pkg::SUM_BITS-1:0]           x_ext, old_ext;
    logic [wsf_pkg::COEFF_BITS-1:0]         coeff;
    logic signed [wsf_pkg::DIFF_BITS-1:0]   mul_b;
    logic signed [wsf_pkg::PROD_BITS-1:0]   mul_p, sh_a, sh_b;
    logic signed [wsf_pkg::ACC_BITS-1:0]    acc_lp, acc_hp;
    logic [wsf_pkg::CNT_BITS:0]             rem_sh;
    logic                                   q_bit;
    logic signed [wsf_pkg::SUM_BITS:0]      q_signed;
    logic [wsf_pkg::RDY_BITS-1:0]           ready_lhs;

    assign x_ext   = wsf_pkg::SUM_BITS'(x_reg);
    assign old_ext = wsf_pkg::SUM_BITS'(rd_data_reg);
    assign wr_addr = wsf_pkg::wrap_add(ptr_reg, count_reg);
    assign rd_addr = (cmd.op == wsf_pkg::DP_RD_IDX) ? wsf_pkg::wrap_add(ptr_reg, idx_reg)
                                                     : ptr_reg;
    assign rd_en   = (cmd.op == wsf_pkg::DP_RD_OLD) || (cmd.op == wsf_pkg::DP_RD_FIRST) ||
                     (cmd.op == wsf_pkg::DP_RD_IDX);

    // shared multiplier: coefficient times a difference or the state
    assign coeff = cmd.lowpass ? lowpass_coeff : highpass_coeff;
    always_comb
    begin
        if (cmd.op == wsf_pkg::DP_MUL_A)
        begin
            mul_b = cmd.lowpass ? (wsf_pkg::DIFF_BITS'(rd_data_reg) - wsf_pkg::DIFF_BITS'(y_reg))
                                : wsf_pkg::DIFF_BITS'(y_reg);
        end
        else
        begin
            mul_b = wsf_pkg::DIFF_BITS'(cur_reg) - wsf_pkg::DIFF_BITS'(prev_reg);
        end
    end
    assign mul_p = $signed({1'b0, coeff}) * mul_b;

    assign sh_a   = prod_a_reg >>> wsf_pkg::COEFF_FRAC_BITS;
    assign sh_b   = prod_b_reg >>> wsf_pkg::COEFF_FRAC_BITS;
    assign acc_lp = wsf_pkg::ACC_BITS'(y_reg) + wsf_pkg::ACC_BITS'(sh_a);
    assign acc_hp = wsf_pkg::ACC_BITS'(sh_a) + wsf_pkg::ACC_BITS'(sh_b);

    // restoring divider, one quotient bit a cycle
    assign rem_sh = {rem_reg, mag_reg[wsf_pkg::SUM_BITS-1]};
    assign q_bit  = (rem_sh >= {1'b0, count_reg});
    assign q_signed = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

    assign ready_lhs = wsf_pkg::RDY_BITS'(count_reg) * wsf_pkg::RDY_BITS'(wsf_pkg::READY_SCALE);

    assign status.empty    = (count_reg == '0);
    assign status.ge_eff   = (count_reg >= eff_window);
    assign status.gt_eff   = (count_reg > eff_window);
    assign status.full     = (count_reg >= wsf_pkg::CNT_BITS'(wsf_pkg::WINDOW_DEPTH));
    assign status.lt2      = (count_reg < wsf_pkg::CNT_BITS'(2));
    assign status.idx_done = (idx_reg == count_reg);
    assign status.div_last = (dcnt_reg == wsf_pkg::DCNT_BITS'(wsf_pkg::SUM_BITS - 1));

    assign filtered_out = out_reg;
    assign ready_res    = ready_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.op == wsf_pkg::DP_APPEND)
        begin
            mem[wr_addr] <= x_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        ptr_next   = ptr_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        idx_next   = idx_reg;
        dcnt_next  = dcnt_reg;
        case (cmd.op)
            wsf_pkg::DP_CLEAR:
            begin
                ptr_next   = '0;
                count_next = '0;
                sum_next   = '0;
            end
            wsf_pkg::DP_DROP:
            begin
                ptr_next   = wsf_pkg::wrap_add(ptr_reg, wsf_pkg::CNT_BITS'(1));
                count_next = count_reg - wsf_pkg::CNT_BITS'(1);
                if (cmd.sub)
                begin
                    sum_next = sum_reg - old_ext;
                end
            end
            wsf_pkg::DP_APPEND:   count_next = count_reg + wsf_pkg::CNT_BITS'(1);
            wsf_pkg::DP_SUM_SET:  sum_next = x_ext;
            wsf_pkg::DP_SUM_ADD:  sum_next = sum_reg + x_ext;
            wsf_pkg::DP_RD_FIRST: idx_next = wsf_pkg::CNT_BITS'(1);
            wsf_pkg::DP_UPD_LP:   idx_next = idx_reg + wsf_pkg::CNT_BITS'(1);
            wsf_pkg::DP_UPD_HP:   idx_next = idx_reg + wsf_pkg::CNT_BITS'(1);
            wsf_pkg::DP_DIV_INIT: dcnt_next = '0;
            wsf_pkg::DP_DIV_STEP: dcnt_next = dcnt_reg + wsf_pkg::DCNT_BITS'(1);
            default:              ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            idx_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            idx_reg   <= idx_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            wsf_pkg::DP_LOAD:     x_reg <= sample_in;
            wsf_pkg::DP_CLEAR:    y_reg <= '0;
            wsf_pkg::DP_Y_X:      y_reg <= x_reg;
            wsf_pkg::DP_SUM_SET:  y_reg <= x_reg;
            wsf_pkg::DP_Y_INIT:
            begin
                y_reg    <= rd_data_reg;
                prev_reg <= rd_data_reg;
            end
            wsf_pkg::DP_MUL_A:
            begin
                prod_a_reg <= mul_p;
                cur_reg    <= rd_data_reg;
            end
            wsf_pkg::DP_MUL_B:    prod_b_reg <= mul_p;
            wsf_pkg::DP_UPD_LP:
            begin
                y_reg    <= wsf_pkg::sat_sample(wsf_pkg::SAT_BITS'(acc_lp));
                prev_reg <= cur_reg;
            end
            wsf_pkg::DP_UPD_HP:
            begin
                y_reg    <= wsf_pkg::sat_sample(wsf_pkg::SAT_BITS'(acc_hp));
                prev_reg <= cur_reg;
            end
            wsf_pkg::DP_DIV_INIT:
            begin
                neg_reg <= sum_reg[wsf_pkg::SUM_BITS-1];
                mag_reg <= sum_reg[wsf_pkg::SUM_BITS-1] ? (~sum_reg + 1'b1) : sum_reg;
                rem_reg <= '0;
            end
            wsf_pkg::DP_DIV_STEP:
            begin
                rem_reg <= q_bit ? wsf_pkg::CNT_BITS'(rem_sh - {1'b0, count_reg})
                                 : rem_sh[wsf_pkg::CNT_BITS-1:0];
                mag_reg <= {mag_reg[wsf_pkg::SUM_BITS-2:0], q_bit};
            end
            wsf_pkg::DP_Y_DIV:
            begin
                y_reg <= wsf_pkg::sat_sample(wsf_pkg::SAT_BITS'(q_signed));
            end
            wsf_pkg::DP_RESULT:
            begin
                out_reg   <= y_reg;
                ready_reg <= (ready_lhs >= wsf_pkg::RDY_BITS'(eff_window));
            end
            default:              x_reg <= x_reg;
        endcase
    end

endmodule

### rtl/windowed_sensor_filter_unit.sv
// ----------------------------------------------------------------------------
// windowed_sensor_filter_unit
// Sensor filter over a sliding sample history: low-pass, high-pass, moving
// average or pass-through, with a clear operation.
// ----------------------------------------------------------------------------
// One word is processed at a time; a new word is taken as soon as the
// previous one has reached the output register. Low-pass and high-pass
// replay the recursion over the samples held after the push (the sample
// itself is the result while fewer than two are held) through the single
// history read port and one shared multiplier, which high-pass uses twice
// per sample. Moving average divides the running sum in the 64-step serial
// divider (a first sample after empty or clear passes through). Registers:
// 0 filter mode, 1 window size, 2 low-pass alpha, 3 high-pass alpha; write
// only while idle.
// ----------------------------------------------------------------------------
module windowed_sensor_filter_unit
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_write,
    input  logic [1:0]                                cfg_index,
    input  logic [wsf_pkg::CFG_BITS-1:0]              cfg_data,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic                                      operation,
    input  logic signed [wsf_pkg::SAMPLE_BITS-1:0]    sample_in,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [wsf_pkg::SAMPLE_BITS-1:0]    filtered_out,
    output logic                                      ready_res
);

    localparam int EW = wsf_pkg::WIN_BITS + wsf_pkg::CNT_BITS;

    wsf_pkg::mode_t                     mode_reg;
    logic [wsf_pkg::WIN_BITS-1:0]       window_reg;
    logic [wsf_pkg::COEFF_BITS-1:0]     lp_coeff_reg, hp_coeff_reg;
    logic [wsf_pkg::CNT_BITS-1:0]       eff_window;
    logic [EW-1:0]                      win_ext;
    wsf_pkg::status_t                   status;
    wsf_pkg::cmd_t                      cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= wsf_pkg::MODE_PASS;
            window_reg   <= wsf_pkg::WIN_BITS'(10);
            lp_coeff_reg <= wsf_pkg::COEFF_BITS'(1) << (wsf_pkg::COEFF_FRAC_BITS - 1);
            hp_coeff_reg <= wsf_pkg::COEFF_BITS'(1) << (wsf_pkg::COEFF_FRAC_BITS - 1);
        end
        else if (cfg_write)
        begin
            case (wsf_pkg::reg_index_t'(cfg_index))
                wsf_pkg::REG_FILTER_MODE:    mode_reg     <= wsf_pkg::mode_t'(cfg_data[1:0]);
                wsf_pkg::REG_WINDOW_SIZE:    window_reg   <= cfg_data[wsf_pkg::WIN_BITS-1:0];
                wsf_pkg::REG_LOWPASS_COEFF:  lp_coeff_reg <= cfg_data[wsf_pkg::COEFF_BITS-1:0];
                wsf_pkg::REG_HIGHPASS_COEFF: hp_coeff_reg <= cfg_data[wsf_pkg::COEFF_BITS-1:0];
                default:                     mode_reg     <= mode_reg;
            endcase
        end
    end

    // window clamped to 1..depth
    assign win_ext = EW'(window_reg);
    always_comb
    begin
        if (win_ext == '0)
        begin
            eff_window = wsf_pkg::CNT_BITS'(1);
        end
        else if (win_ext > EW'(wsf_pkg::WINDOW_DEPTH))
        begin
            eff_window = wsf_pkg::CNT_BITS'(wsf_pkg::WINDOW_DEPTH);
        end
        else
        begin
            eff_window = win_ext[wsf_pkg::CNT_BITS-1:0];
        end
    end

    wsf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .mode      (mode_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    wsf_dpath u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sample_in      (sample_in),
        .eff_window     (eff_window),
        .lowpass_coeff  (lp_coeff_reg),
        .highpass_coeff (hp_coeff_reg),
        .status         (status),
        .filtered_out   (filtered_out),
        .ready_res      (ready_res)
    );

endmodule
